// ===== hw/rtl/cap_pkg.sv =====
package cap_pkg;

    // Field widths
    localparam int COORD_WIDTH     = 24;
    localparam int PHASE_WIDTH     = 16;
    localparam int TURNS_WIDTH     = 5;
    localparam int CFG_INDEX_WIDTH = 3;

    // CORDIC configuration
    localparam int CORDIC_STAGES = 16;
    localparam int MAX_STAGES    = 24;
    localparam int GUARD_BITS    = 6;

    // Angle in the rotator is in units of 2^-32 turn
    localparam int ANGLE_FRAC = 32 - PHASE_WIDTH;

    // Datapath widths: difference vector after the quadrant swap, rotator x/y
    // (room for the CORDIC gain and the diagonal), and rotator angle
    localparam int DIFF_WIDTH = COORD_WIDTH + 2;
    localparam int XY_WIDTH   = DIFF_WIDTH + GUARD_BITS + 2;
    localparam int Z_WIDTH    = 34;

    // Gain correction: v * KINV / 2^30, split into a high and a low product
    localparam int KINV_WIDTH = 30;
    localparam int KINV_FRAC  = 30;
    localparam logic [KINV_WIDTH-1:0] KINV = KINV_WIDTH'(652032874);
    localparam int GAIN_SPLIT = 16;
    localparam int GAIN_SHIFT = KINV_FRAC - GAIN_SPLIT;
    localparam int HI_WIDTH   = XY_WIDTH - GAIN_SPLIT;
    localparam int HIP_WIDTH  = HI_WIDTH + KINV_WIDTH + 1;
    localparam int LOP_WIDTH  = GAIN_SPLIT + KINV_WIDTH;

    // Final sum width
    localparam int FIN_WIDTH = XY_WIDTH + 2;

    // Per-stage arctangent, round(atan(2^-i) / (2*pi) * 2^32)
    localparam logic [31:0] ATAN_TURNS [0:MAX_STAGES-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_START_X = 3'd0,
        REG_START_Y = 3'd1,
        REG_END_X   = 3'd2,
        REG_END_Y   = 3'd3,
        REG_TURNS   = 3'd4
    } cfg_reg_t;

endpackage

// ===== hw/rtl/circular_arc_point_generator.sv =====
// Pipeline: a phase accepted into the prepare stage passes through the rotator and gain stages
// to the output register that drives point valid; CORDIC_STAGES + 4 register stages in all.
// Throughput: one item per cycle unless the output stalls; every stage of the unrolled CORDIC
// rotator, the gain multiply and gain sum stages and the output register each take a new item every clock.
// A stalled output holds its item; upstream stages keep filling empty slots.
// Reset (rst_n low, asynchronous): pipeline emptied, start/end points cleared, turns = 1.
module circular_arc_point_generator
    import cap_pkg::*;
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_wr_en,
    input  logic        [CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic        [COORD_WIDTH-1:0]       cfg_data,

    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic        [PHASE_WIDTH:0]         phase,

    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [COORD_WIDTH-1:0]       pos_x,
    output logic signed [COORD_WIDTH-1:0]       pos_y
);

    // Stage map: 0 prepare, 1..CORDIC_STAGES rotate, then gain multiply,
    // gain sum and the output register
    localparam int NUM_STAGES = CORDIC_STAGES + 4;
    localparam int ST_GMUL    = CORDIC_STAGES + 1;
    localparam int ST_GSUM    = CORDIC_STAGES + 2;
    localparam int ST_OUT     = CORDIC_STAGES + 3;

    // Configuration registers
    logic signed [COORD_WIDTH-1:0] start_x_reg, start_y_reg, end_x_reg, end_y_reg;
    logic signed [TURNS_WIDTH-1:0] turns_reg;

    // Pipeline control
    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] en;

    // Rotator registers
    logic signed [XY_WIDTH-1:0] x_reg [0:CORDIC_STAGES];
    logic signed [XY_WIDTH-1:0] y_reg [0:CORDIC_STAGES];
    logic signed [Z_WIDTH-1:0]  z_reg [0:CORDIC_STAGES];

    // Gain registers
    logic signed [HIP_WIDTH-1:0] hx_reg, hy_reg;
    logic        [LOP_WIDTH-1:0] lx_reg, ly_reg;
    logic signed [XY_WIDTH-1:0]  vx_reg, vy_reg;

    // Output registers
    logic signed [COORD_WIDTH-1:0] pos_x_reg, pos_y_reg;

    //------------------------------------------------------------------
    // Configuration write
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg <= '0;
            start_y_reg <= '0;
            end_x_reg   <= '0;
            end_y_reg   <= '0;
            turns_reg   <= TURNS_WIDTH'(1);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_START_X: start_x_reg <= cfg_data;
                REG_START_Y: start_y_reg <= cfg_data;
                REG_END_X:   end_x_reg   <= cfg_data;
                REG_END_Y:   end_y_reg   <= cfg_data;
                REG_TURNS:   turns_reg   <= cfg_data[TURNS_WIDTH-1:0];
                default:     ;
            endcase
        end
    end

    //------------------------------------------------------------------
    // Stage enables: a stage loads when empty or when its item moves on
    //------------------------------------------------------------------
    assign en[NUM_STAGES-1] = ~vld_reg[NUM_STAGES-1] | out_ready;

    for (genvar gk = 0; gk < NUM_STAGES - 1; gk++)
    begin : g_en
        assign en[gk] = ~vld_reg[gk] | en[gk+1];
    end

    assign in_ready = en[0];

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    //------------------------------------------------------------------
    // Stage 0: angle, quadrant swap of the difference vector
    //------------------------------------------------------------------
    logic        [PHASE_WIDTH-1:0]   turns_ext;
    logic        [2*PHASE_WIDTH-1:0] ang_full;
    logic        [PHASE_WIDTH-1:0]   ang;
    logic        [1:0]               quad;
    logic signed [DIFF_WIDTH-1:0]    dx, dy, rx, ry;
    logic signed [XY_WIDTH-1:0]      x0_next, y0_next;
    logic signed [Z_WIDTH-1:0]       z0_next;

    always_comb
    begin
        turns_ext = PHASE_WIDTH'(turns_reg);
        ang_full  = phase[PHASE_WIDTH-1:0] * turns_ext;
        ang       = ang_full[PHASE_WIDTH-1:0];
        quad      = ang[PHASE_WIDTH-1:PHASE_WIDTH-2];
        dx        = DIFF_WIDTH'(start_x_reg) - DIFF_WIDTH'(end_x_reg);
        dy        = DIFF_WIDTH'(start_y_reg) - DIFF_WIDTH'(end_y_reg);
        unique case (quad)
            2'd0:    begin rx = dx;  ry = dy;  end
            2'd1:    begin rx = -dy; ry = dx;  end
            2'd2:    begin rx = -dx; ry = -dy; end
            default: begin rx = dy;  ry = -dx; end
        endcase
        x0_next = XY_WIDTH'(rx) <<< GUARD_BITS;
        y0_next = XY_WIDTH'(ry) <<< GUARD_BITS;
        z0_next = Z_WIDTH'({ang[PHASE_WIDTH-3:0], {ANGLE_FRAC{1'b0}}});
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            x_reg[0] <= x0_next;
            y_reg[0] <= y0_next;
            z_reg[0] <= z0_next;
        end
    end

    //------------------------------------------------------------------
    // Rotator: one micro-rotation per stage
    //------------------------------------------------------------------
    for (genvar gi = 0; gi < CORDIC_STAGES; gi++)
    begin : g_cordic
        logic signed [XY_WIDTH-1:0] x_next, y_next;
        logic signed [Z_WIDTH-1:0]  z_next;
        logic signed [Z_WIDTH-1:0]  atan_step;

        always_comb
        begin
            atan_step = Z_WIDTH'(ATAN_TURNS[gi]);
            if (!z_reg[gi][Z_WIDTH-1])
            begin
                x_next = x_reg[gi] - (y_reg[gi] >>> gi);
                y_next = y_reg[gi] + (x_reg[gi] >>> gi);
                z_next = z_reg[gi] - atan_step;
            end
            else
            begin
                x_next = x_reg[gi] + (y_reg[gi] >>> gi);
                y_next = y_reg[gi] - (x_reg[gi] >>> gi);
                z_next = z_reg[gi] + atan_step;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[gi+1])
            begin
                x_reg[gi+1] <= x_next;
                y_reg[gi+1] <= y_next;
                z_reg[gi+1] <= z_next;
            end
        end
    end

    //------------------------------------------------------------------
    // Gain correction, multiply: high and low halves against KINV
    //------------------------------------------------------------------
    logic signed [HI_WIDTH-1:0]   xh, yh;
    logic signed [KINV_WIDTH:0]   kinv_s;
    logic signed [HIP_WIDTH-1:0]  hx_next, hy_next;
    logic        [LOP_WIDTH-1:0]  lx_next, ly_next;

    always_comb
    begin
        xh      = x_reg[CORDIC_STAGES][XY_WIDTH-1:GAIN_SPLIT];
        yh      = y_reg[CORDIC_STAGES][XY_WIDTH-1:GAIN_SPLIT];
        kinv_s  = signed'({1'b0, KINV});
        hx_next = xh * kinv_s;
        hy_next = yh * kinv_s;
        lx_next = x_reg[CORDIC_STAGES][GAIN_SPLIT-1:0] * KINV;
        ly_next = y_reg[CORDIC_STAGES][GAIN_SPLIT-1:0] * KINV;
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_GMUL])
        begin
            hx_reg <= hx_next;
            hy_reg <= hy_next;
            lx_reg <= lx_next;
            ly_reg <= ly_next;
        end
    end

    //------------------------------------------------------------------
    // Gain correction, sum and round
    //------------------------------------------------------------------
    logic signed [HIP_WIDTH:0]  gx_sum, gy_sum, gx_shr, gy_shr;
    logic signed [XY_WIDTH-1:0] vx_next, vy_next;

    always_comb
    begin
        gx_sum  = (HIP_WIDTH+1)'(hx_reg) + (HIP_WIDTH+1)'(lx_reg >> GAIN_SPLIT)
                + (HIP_WIDTH+1)'(1 << (GAIN_SHIFT - 1));
        gy_sum  = (HIP_WIDTH+1)'(hy_reg) + (HIP_WIDTH+1)'(ly_reg >> GAIN_SPLIT)
                + (HIP_WIDTH+1)'(1 << (GAIN_SHIFT - 1));
        gx_shr  = gx_sum >>> GAIN_SHIFT;
        gy_shr  = gy_sum >>> GAIN_SHIFT;
        vx_next = gx_shr[XY_WIDTH-1:0];
        vy_next = gy_shr[XY_WIDTH-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_GSUM])
        begin
            vx_reg <= vx_next;
            vy_reg <= vy_next;
        end
    end

    //------------------------------------------------------------------
    // Output: add back the center, round, saturate
    //------------------------------------------------------------------
    logic signed [COORD_WIDTH:0]    c2x, c2y;
    logic signed [FIN_WIDTH-1:0]    fx_sum, fy_sum, fx_shr, fy_shr;
    logic                           fx_ovf, fy_ovf;
    logic signed [COORD_WIDTH-1:0]  pos_x_next, pos_y_next;

    always_comb
    begin
        c2x    = (COORD_WIDTH+1)'(start_x_reg) + (COORD_WIDTH+1)'(end_x_reg);
        c2y    = (COORD_WIDTH+1)'(start_y_reg) + (COORD_WIDTH+1)'(end_y_reg);
        fx_sum = (FIN_WIDTH'(c2x) <<< GUARD_BITS) + FIN_WIDTH'(vx_reg)
               + FIN_WIDTH'(1 << GUARD_BITS);
        fy_sum = (FIN_WIDTH'(c2y) <<< GUARD_BITS) + FIN_WIDTH'(vy_reg)
               + FIN_WIDTH'(1 << GUARD_BITS);
        fx_shr = fx_sum >>> (GUARD_BITS + 1);
        fy_shr = fy_sum >>> (GUARD_BITS + 1);
        // out of range when the bits above the sign disagree with it
        fx_ovf = (fx_shr[FIN_WIDTH-1:COORD_WIDTH-1] != '0)
              && (fx_shr[FIN_WIDTH-1:COORD_WIDTH-1] != '1);
        fy_ovf = (fy_shr[FIN_WIDTH-1:COORD_WIDTH-1] != '0)
              && (fy_shr[FIN_WIDTH-1:COORD_WIDTH-1] != '1);
        if (fx_ovf)
        begin
            pos_x_next = {fx_shr[FIN_WIDTH-1], {(COORD_WIDTH-1){~fx_shr[FIN_WIDTH-1]}}};
        end
        else
        begin
            pos_x_next = fx_shr[COORD_WIDTH-1:0];
        end
        if (fy_ovf)
        begin
            pos_y_next = {fy_shr[FIN_WIDTH-1], {(COORD_WIDTH-1){~fy_shr[FIN_WIDTH-1]}}};
        end
        else
        begin
            pos_y_next = fy_shr[COORD_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
        begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
        end
    end

    assign out_valid = vld_reg[ST_OUT];
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;

    //------------------------------------------------------------------
    // Assertions
    //------------------------------------------------------------------
    // An empty output stage lets every stage load
    a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !vld_reg[ST_OUT] |-> in_ready)
        else $error("input stalled with an empty output stage");

    // A taken output frees the whole pipe
    a_out_ready_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output is taken");

    // An accepted item lands in the first stage
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> vld_reg[0])
        else $error("accepted item lost at the first stage");

    // A held output item is not overwritten by the stage behind it
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(pos_x_reg)
                                       && $stable(pos_y_reg)))
        else $error("held output item changed");

endmodule
